// ===== sv/a2i_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2i_pkg
// Shared constants and types of the character-serial integer parser.
// ----------------------------------------------------------------------------
package a2i_pkg;

   localparam int VALUE_BITS    = 64;
   localparam int POSITION_BITS = 16;
   localparam int BASE_W        = 6;
   localparam int CHAR_W        = 8;
   localparam int DIGIT_W       = 6;
   localparam int OUT_VALUE_W   = 64;
   localparam int OUT_COUNT_W   = 16;
   localparam int RSP_DATA_W    = 88;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 6;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = 1;
   localparam int QUEUE_CNT_W   = 2;
   localparam int PROD_W        = VALUE_BITS + BASE_W + 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_BASE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNED_MODE = 1'd1;

   localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
   localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

   localparam logic [DIGIT_W-1:0] DIGIT_NONE = '1;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UX    = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LX    = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX  = '1;
   localparam logic [VALUE_BITS-1:0] SIGNED_MAX = VALUE_MAX >> 1;
   localparam logic [VALUE_BITS-1:0] SIGNED_MIN = SIGNED_MAX + 1'b1;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   typedef struct packed {
      logic is_space;
      logic is_plus;
      logic is_minus;
      logic is_zero;
      logic is_x;
      logic is_nul;
      logic is_last;
      logic first;
   } char_class_type;

   typedef struct packed {
      char_class_type       cls;
      logic [DIGIT_W-1:0]   digit;
      logic [BASE_W-1:0]    base;
   } token_type;

endpackage

// ===== sv/ascii_to_integer_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_to_integer_parser_unit
// Character-serial integer parser: one byte per transfer, one result per
// string with value, consumed count and status flags.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, set by the combinational multiply-add
//   and limit compare of the parse engine; a string end waits for a held result.
// Result path: the terminating character is written to the queue, then the
//   result is taken into the result register.
// Reset: synchronous; clears the queue, parse state and result valid flag,
//   and sets the base to 10 and signed mode off.
module ascii_to_integer_parser_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [a2i_pkg::CHAR_W-1:0]          req_tdata,   // [7:0] char_code
   input  logic                                req_tlast,   // end_of_string
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [63:0] parsed_value, [79:64] consumed_count, [80] range_error,
   // [81] bad_base, [82] any_digits, [87:83] zero
   output logic [a2i_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [a2i_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [a2i_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   logic [a2i_pkg::BASE_W-1:0]          number_base_ff, number_base_in;
   logic                                signed_mode_ff, signed_mode_in;

   logic                                req_accept;
   logic                                queue_full;
   logic                                queue_not_empty;
   logic                                queue_pop;
   a2i_pkg::token_type                  front_token;
   a2i_pkg::token_type                  head_token;
   logic [a2i_pkg::OUT_VALUE_W-1:0]     res_value;
   logic [a2i_pkg::OUT_COUNT_W-1:0]     res_count;
   logic                                res_range_error;
   logic                                res_bad_base;
   logic                                res_any_digits;

   always_comb begin
      number_base_in = number_base_ff;
      signed_mode_in = signed_mode_ff;
      if (csr_wr_en) begin
         case (csr_index)
            a2i_pkg::CSR_NUMBER_BASE: number_base_in = csr_wr_data[a2i_pkg::BASE_W-1:0];
            a2i_pkg::CSR_SIGNED_MODE: signed_mode_in = csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= a2i_pkg::BASE_RESET;
         signed_mode_ff <= 1'b0;
      end else begin
         number_base_ff <= number_base_in;
         signed_mode_ff <= signed_mode_in;
      end
   end

   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && !queue_full;

   a2i_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .char_code     (req_tdata),
      .end_of_string (req_tlast),
      .number_base   (number_base_ff),
      .token         (front_token)
   );

   a2i_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_token (front_token),
      .full       (queue_full),
      .pop        (queue_pop),
      .not_empty  (queue_not_empty),
      .head_token (head_token)
   );

   a2i_back u_back (
      .clock           (clock),
      .reset           (reset),
      .tok_valid       (queue_not_empty),
      .tok             (head_token),
      .tok_pop         (queue_pop),
      .signed_mode     (signed_mode_ff),
      .res_valid       (rsp_tvalid),
      .res_ready       (rsp_tready),
      .res_value       (res_value),
      .res_count       (res_count),
      .res_range_error (res_range_error),
      .res_bad_base    (res_bad_base),
      .res_any_digits  (res_any_digits)
   );

   assign rsp_tdata = {5'b0, res_any_digits, res_bad_base, res_range_error,
                       res_count, res_value};

endmodule

// ===== sv/a2i_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2i_front
// Classifies each incoming character, tags it with the current base and marks the first character of a string.
// ----------------------------------------------------------------------------
module a2i_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [a2i_pkg::CHAR_W-1:0]    char_code,
   input  logic                          end_of_string,
   input  logic [a2i_pkg::BASE_W-1:0]    number_base,
   output a2i_pkg::token_type            token
);

   logic sof_ff;
   logic sof_in;
   logic [a2i_pkg::CHAR_W-1:0] ofs;

   always_comb begin
      token = '0;
      ofs   = '0;
      token.cls.is_space = (char_code == a2i_pkg::CHAR_SPACE) ||
                           ((char_code >= a2i_pkg::CHAR_TAB) &&
                            (char_code <= a2i_pkg::CHAR_CR));
      token.cls.is_plus  = (char_code == a2i_pkg::CHAR_PLUS);
      token.cls.is_minus = (char_code == a2i_pkg::CHAR_MINUS);
      token.cls.is_zero  = (char_code == a2i_pkg::CHAR_ZERO);
      token.cls.is_x     = (char_code == a2i_pkg::CHAR_LX) ||
                           (char_code == a2i_pkg::CHAR_UX);
      token.cls.is_nul   = (char_code == a2i_pkg::CHAR_NUL);
      token.cls.is_last  = end_of_string;
      token.cls.first    = sof_ff;
      token.base         = number_base;
      token.digit        = a2i_pkg::DIGIT_NONE;
      if ((char_code >= a2i_pkg::CHAR_ZERO) && (char_code <= a2i_pkg::CHAR_NINE)) begin
         ofs = char_code - a2i_pkg::CHAR_ZERO;
         token.digit = ofs[a2i_pkg::DIGIT_W-1:0];
      end else if ((char_code >= a2i_pkg::CHAR_UA) && (char_code <= a2i_pkg::CHAR_UZ)) begin
         ofs = char_code - a2i_pkg::CHAR_UA + 8'd10;
         token.digit = ofs[a2i_pkg::DIGIT_W-1:0];
      end else if ((char_code >= a2i_pkg::CHAR_LA) && (char_code <= a2i_pkg::CHAR_LZ)) begin
         ofs = char_code - a2i_pkg::CHAR_LA + 8'd10;
         token.digit = ofs[a2i_pkg::DIGIT_W-1:0];
      end
   end

   assign sof_in = accept ? (token.cls.is_nul || end_of_string) : sof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sof_ff <= 1'b1;
      end else begin
         sof_ff <= sof_in;
      end
   end

endmodule

// ===== sv/a2i_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2i_queue
// Two-entry token queue between the classifier and the parse engine.
// ----------------------------------------------------------------------------
module a2i_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  a2i_pkg::token_type  push_token,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output a2i_pkg::token_type  head_token
);

   a2i_pkg::token_type slot_ff [a2i_pkg::QUEUE_DEPTH];
   logic [a2i_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [a2i_pkg::QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [a2i_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [a2i_pkg::QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [a2i_pkg::QUEUE_CNT_W-1:0] count_ff;
   logic [a2i_pkg::QUEUE_CNT_W-1:0] count_in;

   assign full       = (count_ff == a2i_pkg::QUEUE_CNT_W'(a2i_pkg::QUEUE_DEPTH));
   assign not_empty  = (count_ff != '0);
   assign head_token = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/a2i_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2i_back
// Parse engine: sign, prefix and digit handling, saturating accumulate,
// and the registered result.
// ----------------------------------------------------------------------------
module a2i_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               tok_valid,
   input  a2i_pkg::token_type                 tok,
   output logic                               tok_pop,
   input  logic                               signed_mode,
   output logic                               res_valid,
   input  logic                               res_ready,
   output logic [a2i_pkg::OUT_VALUE_W-1:0]    res_value,
   output logic [a2i_pkg::OUT_COUNT_W-1:0]    res_count,
   output logic                               res_range_error,
   output logic                               res_bad_base,
   output logic                               res_any_digits
);

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_XMARK,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   phase_type                            phase_ff, phase_in;
   logic                                 neg_ff, neg_in;
   logic [a2i_pkg::BASE_W-1:0]           base_ff, base_in;
   logic [a2i_pkg::VALUE_BITS-1:0]       acc_ff, acc_in;
   logic                                 ovf_ff, ovf_in;
   logic                                 seen_ff, seen_in;
   logic [a2i_pkg::POSITION_BITS-1:0]    idx_ff, idx_in;
   logic [a2i_pkg::POSITION_BITS-1:0]    endp_ff, endp_in;

   logic                                 out_valid_ff, out_valid_in;
   logic [a2i_pkg::OUT_VALUE_W-1:0]      out_value_ff, out_value_in;
   logic [a2i_pkg::OUT_COUNT_W-1:0]      out_count_ff, out_count_in;
   logic                                 out_range_ff, out_range_in;
   logic                                 out_bad_ff, out_bad_in;
   logic                                 out_any_ff, out_any_in;

   logic [a2i_pkg::BASE_W-1:0]           base_cur;
   logic [a2i_pkg::BASE_W-1:0]           base_eff;
   logic                                 bad;
   logic                                 run;
   logic                                 first_char;
   logic                                 take;
   logic                                 stop;
   logic                                 zero_lead;
   logic                                 to_signed;
   logic                                 to_xmark;
   logic                                 is_end;
   logic [a2i_pkg::POSITION_BITS-1:0]    idx_next;
   logic [a2i_pkg::VALUE_BITS-1:0]       acc_src;
   logic [a2i_pkg::PROD_W-1:0]           prod;
   logic [a2i_pkg::VALUE_BITS-1:0]       limit;
   logic [a2i_pkg::VALUE_BITS-1:0]       value_w;

   assign tok_pop = tok_valid && (!is_end || !out_valid_ff || res_ready);

   always_comb begin
      base_cur  = tok.cls.first ? tok.base : base_ff;
      bad       = (base_cur == a2i_pkg::BASE_ONE) || (base_cur > a2i_pkg::BASE_MAX);
      run       = !tok.cls.is_nul && !bad;
      is_end    = tok.cls.is_nul || tok.cls.is_last;
      idx_next  = (idx_ff == a2i_pkg::POS_MAX) ? idx_ff : idx_ff + 1'b1;

      base_eff  = base_cur;
      take      = 1'b0;
      stop      = 1'b0;
      zero_lead = 1'b0;
      to_signed = 1'b0;
      to_xmark  = 1'b0;
      first_char = 1'b0;

      case (phase_ff)
         PH_SPACE: begin
            if (tok.cls.is_plus || tok.cls.is_minus) begin
               to_signed = 1'b1;
            end else if (!tok.cls.is_space) begin
               first_char = 1'b1;
            end
         end
         PH_SIGNED: begin
            first_char = 1'b1;
         end
         PH_ZERO: begin
            if (tok.cls.is_x) begin
               to_xmark = 1'b1;
            end else begin
               base_eff = (base_cur == a2i_pkg::BASE_AUTO) ? a2i_pkg::BASE_OCT : base_cur;
               take = (tok.digit < base_eff);
               stop = !take;
            end
         end
         PH_XMARK: begin
            if (tok.digit < a2i_pkg::BASE_HEX) begin
               base_eff = a2i_pkg::BASE_HEX;
               take = 1'b1;
            end else begin
               stop = 1'b1;
            end
         end
         PH_DIGITS: begin
            take = (tok.digit < base_eff);
            stop = !take;
         end
         default: begin
         end
      endcase

      if (first_char) begin
         if (tok.cls.is_zero) begin
            if ((base_cur == a2i_pkg::BASE_AUTO) || (base_cur == a2i_pkg::BASE_HEX)) begin
               zero_lead = 1'b1;
            end else begin
               take = 1'b1;
            end
         end else begin
            base_eff = (base_cur == a2i_pkg::BASE_AUTO) ? a2i_pkg::BASE_DEC : base_cur;
            take = (tok.digit < base_eff);
            stop = !take;
         end
      end

      acc_src = (phase_ff == PH_XMARK) ? '0 : acc_ff;
      prod    = a2i_pkg::PROD_W'(acc_src) * a2i_pkg::PROD_W'(base_eff) +
                a2i_pkg::PROD_W'(tok.digit);
      if (signed_mode) begin
         limit = neg_ff ? a2i_pkg::SIGNED_MIN : a2i_pkg::SIGNED_MAX;
      end else begin
         limit = a2i_pkg::VALUE_MAX;
      end

      phase_in = phase_ff;
      neg_in   = neg_ff;
      base_in  = base_cur;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      seen_in  = seen_ff;
      idx_in   = idx_ff;
      endp_in  = endp_ff;

      if (run) begin
         base_in = base_eff;
         if (to_signed) begin
            neg_in   = tok.cls.is_minus;
            phase_in = PH_SIGNED;
         end
         if (to_xmark) begin
            phase_in = PH_XMARK;
         end
         if (zero_lead) begin
            seen_in  = 1'b1;
            acc_in   = '0;
            endp_in  = idx_next;
            phase_in = PH_ZERO;
         end
         if (take) begin
            if (!ovf_ff) begin
               if (prod > a2i_pkg::PROD_W'(limit)) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = prod[a2i_pkg::VALUE_BITS-1:0];
               end
            end
            seen_in  = 1'b1;
            endp_in  = idx_next;
            phase_in = PH_DIGITS;
         end
         if (stop) begin
            phase_in = PH_DONE;
         end
      end
      if (!tok.cls.is_nul) begin
         idx_in = idx_next;
      end

      value_w = '0;
      if (seen_in) begin
         if (ovf_in) begin
            value_w = limit;
         end else begin
            value_w = neg_in ? ('0 - acc_in) : acc_in;
         end
      end

      out_valid_in = out_valid_ff && !res_ready;
      out_value_in = out_value_ff;
      out_count_in = out_count_ff;
      out_range_in = out_range_ff;
      out_bad_in   = out_bad_ff;
      out_any_in   = out_any_ff;

      if (tok_pop && is_end) begin
         out_valid_in = 1'b1;
         if (bad) begin
            out_value_in = '0;
            out_count_in = '0;
            out_range_in = 1'b0;
            out_bad_in   = 1'b1;
            out_any_in   = 1'b0;
         end else begin
            if (signed_mode) begin
               out_value_in = a2i_pkg::OUT_VALUE_W'(signed'(value_w));
            end else begin
               out_value_in = a2i_pkg::OUT_VALUE_W'(value_w);
            end
            out_count_in = seen_in ? a2i_pkg::OUT_COUNT_W'(endp_in) : '0;
            out_range_in = seen_in && ovf_in;
            out_bad_in   = 1'b0;
            out_any_in   = seen_in;
         end
         phase_in = PH_SPACE;
         neg_in   = 1'b0;
         base_in  = '0;
         acc_in   = '0;
         ovf_in   = 1'b0;
         seen_in  = 1'b0;
         idx_in   = '0;
         endp_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SPACE;
         neg_ff       <= 1'b0;
         base_ff      <= '0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         idx_ff       <= '0;
         endp_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (tok_pop) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            base_ff  <= base_in;
            acc_ff   <= acc_in;
            ovf_ff   <= ovf_in;
            seen_ff  <= seen_in;
            idx_ff   <= idx_in;
            endp_ff  <= endp_in;
         end
         out_valid_ff <= out_valid_in;
      end
      out_value_ff <= out_value_in;
      out_count_ff <= out_count_in;
      out_range_ff <= out_range_in;
      out_bad_ff   <= out_bad_in;
      out_any_ff   <= out_any_in;
   end

   assign res_valid       = out_valid_ff;
   assign res_value       = out_value_ff;
   assign res_count       = out_count_ff;
   assign res_range_error = out_range_ff;
   assign res_bad_base    = out_bad_ff;
   assign res_any_digits  = out_any_ff;

endmodule
